// ----- rtl/pairwise_distance_median_top_macros.svh -----
// Assertion macros for the pairwise distance median checker.
// Used by pdm_checker; no other dependencies.
`ifndef PAIRWISE_DISTANCE_MEDIAN_TOP_MACROS_SVH
`define PAIRWISE_DISTANCE_MEDIAN_TOP_MACROS_SVH

// Implication checked while out of reset.
`define PDM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked while out of reset.
`define PDM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define PDM_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/pdm_pkg.sv -----
// Shared constants, types and state encodings for the pairwise distance median.
// No dependencies.
package pdm_pkg;
  localparam int MAX_POINTS  = 64;
  localparam int MAX_DIMS    = 8;
  localparam int COORD_W     = 16;
  localparam int STORE_DEPTH = MAX_POINTS * MAX_DIMS;
  localparam int PAIR_DEPTH  = (MAX_POINTS * (MAX_POINTS - 1)) / 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int PAIR_W      = $clog2(PAIR_DEPTH + 1);
  localparam int PAIR_AW     = $clog2(PAIR_DEPTH);
  localparam int PT_W        = $clog2(MAX_POINTS + 1);
  localparam int DIMS_W      = 4;
  localparam int DIST_W      = 35;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS        = 1'b1;

  typedef enum logic [2:0] {
    T_LOAD, T_CHK, T_DIV, T_RNG, T_DIST, T_SEL, T_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    D_IDLE, D_RA, D_RB, D_DIFF, D_ACC, D_WR
  } dist_state_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CRD, S_CLAT, S_SCAN, S_DRAIN, S_CHK
  } sel_state_t;
endpackage

// ----- rtl/pdm_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module pdm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/pdm_dist.sv -----
// Pair distance engine: walks all point pairs, reads coordinates from the
// coordinate RAM and writes each pair distance to the distance RAM. Uses pdm_pkg.
module pdm_dist (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pdm_pkg::PT_W-1:0]      points,
  input  logic [pdm_pkg::DIMS_W-1:0]    dims,
  input  logic                          mode,
  output logic [pdm_pkg::ADDR_W-1:0]    coord_raddr,
  input  logic [pdm_pkg::COORD_W-1:0]   coord_rdata,
  output logic                          dist_we,
  output logic [pdm_pkg::PAIR_AW-1:0]   dist_waddr,
  output logic [pdm_pkg::DIST_W-1:0]    dist_wdata,
  output logic                          done,
  output logic [pdm_pkg::PAIR_W-1:0]    pairs
);
  import pdm_pkg::*;

  dist_state_t state_r, state_nxt;
  logic [PT_W-1:0]    i_r, i_nxt, j_r, j_nxt;
  logic [ADDR_W-1:0]  bi_r, bi_nxt, bj_r, bj_nxt;
  logic [DIMS_W-1:0]  k_r, k_nxt;
  logic [COORD_W-1:0] a_r, a_nxt;
  logic [DIFF_W-1:0]  diff_r, diff_nxt;
  logic [DIST_W-1:0]  sum_r, sum_nxt;
  logic [PAIR_W-1:0]  pair_r, pair_nxt;
  logic signed [DIFF_W-1:0] d;
  logic [DIST_W-1:0]  term;
  logic [ADDR_W-1:0]  dims_a;

  assign dims_a     = ADDR_W'(dims);
  assign dist_waddr = pair_r[PAIR_AW-1:0];
  assign dist_wdata = sum_r;
  assign pairs      = pair_r;
  assign d = $signed({a_r[COORD_W-1], a_r}) - $signed({coord_rdata[COORD_W-1], coord_rdata});
  assign term = mode ? DIST_W'(diff_r * diff_r) : DIST_W'(diff_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      pair_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pair_r  <= pair_nxt;
    end
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    bi_r   <= bi_nxt;
    bj_r   <= bj_nxt;
    k_r    <= k_nxt;
    a_r    <= a_nxt;
    diff_r <= diff_nxt;
    sum_r  <= sum_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    bi_nxt      = bi_r;
    bj_nxt      = bj_r;
    k_nxt       = k_r;
    a_nxt       = a_r;
    diff_nxt    = diff_r;
    sum_nxt     = sum_r;
    pair_nxt    = pair_r;
    coord_raddr = bi_r + ADDR_W'(k_r);
    dist_we     = 1'b0;
    done        = 1'b0;
    case (state_r)
      D_IDLE: begin
        if (start) begin
          i_nxt     = '0;
          j_nxt     = PT_W'(1);
          bi_nxt    = '0;
          bj_nxt    = dims_a;
          k_nxt     = '0;
          sum_nxt   = '0;
          pair_nxt  = '0;
          state_nxt = D_RA;
        end
      end
      D_RA: begin
        state_nxt = D_RB;
      end
      D_RB: begin
        coord_raddr = bj_r + ADDR_W'(k_r);
        a_nxt       = coord_rdata;
        state_nxt   = D_DIFF;
      end
      D_DIFF: begin
        diff_nxt  = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        state_nxt = D_ACC;
      end
      D_ACC: begin
        sum_nxt = sum_r + term;
        if (k_r == dims - DIMS_W'(1)) begin
          state_nxt = D_WR;
        end else begin
          k_nxt     = k_r + DIMS_W'(1);
          state_nxt = D_RA;
        end
      end
      D_WR: begin
        dist_we   = 1'b1;
        pair_nxt  = pair_r + PAIR_W'(1);
        sum_nxt   = '0;
        k_nxt     = '0;
        state_nxt = D_RA;
        if (j_r == points - PT_W'(1)) begin
          if (i_r == points - PT_W'(2)) begin
            done      = 1'b1;
            state_nxt = D_IDLE;
          end else begin
            i_nxt  = i_r + PT_W'(1);
            j_nxt  = i_r + PT_W'(2);
            bi_nxt = bi_r + dims_a;
            bj_nxt = bi_r + dims_a + dims_a;
          end
        end else begin
          j_nxt  = j_r + PT_W'(1);
          bj_nxt = bj_r + dims_a;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end
endmodule

// ----- rtl/pdm_sel.sv -----
// Median selection by rank counting over the distance RAM: each candidate is
// compared against every stored distance. Uses pdm_pkg.
module pdm_sel (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pdm_pkg::PAIR_W-1:0]  pairs,
  output logic [pdm_pkg::PAIR_AW-1:0] dist_raddr,
  input  logic [pdm_pkg::DIST_W-1:0]  dist_rdata,
  output logic                        done,
  output logic [pdm_pkg::DIST_W-1:0]  median
);
  import pdm_pkg::*;

  sel_state_t state_r, state_nxt;
  logic [PAIR_W-1:0] c_r, c_nxt, t_r, t_nxt, lt_r, lt_nxt, le_r, le_nxt;
  logic [DIST_W-1:0] cand_r, cand_nxt;
  logic              rv_r, rv_nxt;
  logic [PAIR_W-1:0] rank;

  assign rank       = (pairs - PAIR_W'(1)) >> 1;
  assign median     = cand_r;
  assign dist_raddr = (state_r == S_CRD) ? c_r[PAIR_AW-1:0] : t_r[PAIR_AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rv_r    <= rv_nxt;
    end
    c_r    <= c_nxt;
    t_r    <= t_nxt;
    lt_r   <= lt_nxt;
    le_r   <= le_nxt;
    cand_r <= cand_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    c_nxt     = c_r;
    t_nxt     = t_r;
    lt_nxt    = lt_r;
    le_nxt    = le_r;
    cand_nxt  = cand_r;
    rv_nxt    = 1'b0;
    done      = 1'b0;
    if (rv_r) begin
      if (dist_rdata < cand_r) lt_nxt = lt_r + PAIR_W'(1);
      if (dist_rdata <= cand_r) le_nxt = le_r + PAIR_W'(1);
    end
    case (state_r)
      S_IDLE: begin
        if (start) begin
          c_nxt     = '0;
          state_nxt = S_CRD;
        end
      end
      S_CRD: state_nxt = S_CLAT;
      S_CLAT: begin
        cand_nxt  = dist_rdata;
        t_nxt     = '0;
        lt_nxt    = '0;
        le_nxt    = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        rv_nxt = 1'b1;
        t_nxt  = t_r + PAIR_W'(1);
        if (t_r == pairs - PAIR_W'(1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_CHK;
      S_CHK: begin
        if (lt_r <= rank && le_r > rank) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          c_nxt     = c_r + PAIR_W'(1);
          state_nxt = S_CRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ----- rtl/pairwise_distance_median_top.sv -----
// Top level of the pairwise distance median: load sequencer, set checks,
// coordinate and distance RAMs. Uses pdm_pkg, pdm_ram, pdm_dist and pdm_sel.
//
//   channel | ports                                   | direction
//   input   | in_valid, in_stall, in_coord, in_last   | one coordinate per beat
//   result  | out_valid, out_stall, out_median_distance, out_error | one per set
//   config  | cfg_we, cfg_index, cfg_wdata            | register writes
//
// Coordinates load at one beat per cycle into the coordinate RAM.
// After the last beat come the set check, the pair pass (one RAM read port),
// and the median search (one distance RAM read per cycle).
// Input is stalled from the last beat until the result is in the output register.
// Reset is synchronous; the RAMs need no clearing.
module pairwise_distance_median_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [pdm_pkg::COORD_W-1:0]    in_coord,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [pdm_pkg::DIST_W-1:0]            out_median_distance,
  output logic                                  out_error,
  input  logic                                  cfg_we,
  input  logic [pdm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pdm_pkg::DIMS_W-1:0]            cfg_wdata
);
  import pdm_pkg::*;

  top_state_t state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, quo_r, quo_nxt;
  logic              ovf_r, ovf_nxt;
  logic [DIMS_W:0]   rem_r, rem_nxt, rtry;
  logic [DIMS_W-1:0] step_r, step_nxt;
  logic [PT_W-1:0]   points_r, points_nxt;
  logic              mode_r;
  logic [DIMS_W-1:0] dims_r;
  logic              ov_r, ov_nxt, oerr_r, oerr_nxt;
  logic              err_r, err_nxt;
  logic [DIST_W-1:0] omed_r, omed_nxt;
  logic              accept, store_we;
  logic              dist_start, dist_done, sel_start, sel_done;

  logic [ADDR_W-1:0]  coord_raddr;
  logic [COORD_W-1:0] coord_rdata;
  logic               dist_we;
  logic [PAIR_AW-1:0] dist_waddr, dist_raddr;
  logic [DIST_W-1:0]  dist_wdata, dist_rdata, median;
  logic [PAIR_W-1:0]  pairs;

  assign in_stall            = (state_r != T_LOAD);
  assign accept              = in_valid && !in_stall;
  assign store_we            = accept && (cnt_r != CNT_W'(STORE_DEPTH));
  assign out_valid           = ov_r;
  assign out_error           = oerr_r;
  assign out_median_distance = omed_r;

  pdm_ram #(.WIDTH(COORD_W), .DEPTH(STORE_DEPTH)) u_coord_ram (
    .clk(clk), .we(store_we), .waddr(cnt_r[ADDR_W-1:0]), .wdata(in_coord),
    .raddr(coord_raddr), .rdata(coord_rdata)
  );

  pdm_ram #(.WIDTH(DIST_W), .DEPTH(PAIR_DEPTH)) u_dist_ram (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(dist_raddr), .rdata(dist_rdata)
  );

  pdm_dist u_dist (
    .clk(clk), .rst_n(rst_n), .start(dist_start), .points(points_r),
    .dims(dims_r), .mode(mode_r), .coord_raddr(coord_raddr),
    .coord_rdata(coord_rdata), .dist_we(dist_we), .dist_waddr(dist_waddr),
    .dist_wdata(dist_wdata), .done(dist_done), .pairs(pairs)
  );

  pdm_sel u_sel (
    .clk(clk), .rst_n(rst_n), .start(sel_start), .pairs(pairs),
    .dist_raddr(dist_raddr), .dist_rdata(dist_rdata), .done(sel_done),
    .median(median)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
      mode_r  <= 1'b0;
      dims_r  <= DIMS_W'(1);
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we && cfg_index == REG_KERNEL_MODE) mode_r <= cfg_wdata[0];
      if (cfg_we && cfg_index == REG_DIMS) dims_r <= cfg_wdata;
    end
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    step_r   <= step_nxt;
    points_r <= points_nxt;
    err_r    <= err_nxt;
    oerr_r   <= oerr_nxt;
    omed_r   <= omed_nxt;
  end

  assign rtry = {rem_r[DIMS_W-1:0], quo_r[CNT_W-1]};

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    step_nxt   = step_r;
    points_nxt = points_r;
    err_nxt    = err_r;
    ov_nxt     = ov_r && out_stall;
    oerr_nxt   = oerr_r;
    omed_nxt   = omed_r;
    dist_start = 1'b0;
    sel_start  = 1'b0;
    case (state_r)
      T_LOAD: begin
        if (accept) begin
          if (store_we) cnt_nxt = cnt_r + CNT_W'(1);
          else ovf_nxt = 1'b1;
          if (in_last) state_nxt = T_CHK;
        end
      end
      T_CHK: begin
        if (ovf_r || dims_r == '0 || dims_r > DIMS_W'(MAX_DIMS)) begin
          err_nxt   = 1'b1;
          state_nxt = T_OUT;
        end else begin
          quo_nxt   = cnt_r;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = T_DIV;
        end
      end
      T_DIV: begin
        quo_nxt = {quo_r[CNT_W-2:0], 1'b0};
        if (rtry >= {1'b0, dims_r}) begin
          rem_nxt    = rtry - {1'b0, dims_r};
          quo_nxt[0] = 1'b1;
        end else begin
          rem_nxt = rtry;
        end
        step_nxt = step_r + DIMS_W'(1);
        if (step_r == DIMS_W'(CNT_W - 1)) state_nxt = T_RNG;
      end
      T_RNG: begin
        if (rem_r != '0 || quo_r < CNT_W'(2) || quo_r > CNT_W'(MAX_POINTS)) begin
          err_nxt   = 1'b1;
          state_nxt = T_OUT;
        end else begin
          points_nxt = quo_r[PT_W-1:0];
          dist_start = 1'b1;
          state_nxt  = T_DIST;
        end
      end
      T_DIST: begin
        if (dist_done) begin
          sel_start = 1'b1;
          state_nxt = T_SEL;
        end
      end
      T_SEL: begin
        if (sel_done) begin
          err_nxt   = 1'b0;
          state_nxt = T_OUT;
        end
      end
      T_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          oerr_nxt  = err_r;
          omed_nxt  = err_r ? '0 : median;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = T_LOAD;
        end
      end
      default: state_nxt = T_LOAD;
    endcase
  end
endmodule

// ----- rtl/pdm_checker.sv -----
// Port-level checker for the pairwise distance median and its bind.
// Uses pdm_pkg and pairwise_distance_median_top_macros.svh.
`include "pairwise_distance_median_top_macros.svh"

module pdm_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_last,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [pdm_pkg::DIST_W-1:0]   out_median_distance,
  input logic                         out_error
);
  import pdm_pkg::*;

  `PDM_ASSERT_NXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_median_distance) && $stable(out_error),
    "Stalled result beat changed.")
  `PDM_ASSERT_IMP(a_err_zero, out_valid && out_error, out_median_distance == '0,
    "Error result carries a nonzero distance.")
  `PDM_ASSERT_NXT(a_busy_after_last, in_valid && !in_stall && in_last, in_stall,
    "Input taken right after the last beat of a set.")
  `PDM_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_valid,
    "Result valid right after reset.")
endmodule

bind pairwise_distance_median_top pdm_checker u_pdm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_last(in_last), .out_valid(out_valid), .out_stall(out_stall),
  .out_median_distance(out_median_distance), .out_error(out_error)
);

// ----- tb/pairwise_distance_median_top_test.sv -----
// Self-checking testbench for pairwise_distance_median_top: directed and random point sets,
// with a built-in predictor of the median pair distance and a result scoreboard.
// Depends on pdm_pkg and the pairwise_distance_median_top RTL.
module pairwise_distance_median_top_test;
  import pdm_pkg::*;

  typedef struct {
    logic [DIST_W-1:0] median;
    logic              err;
  } median_result_t;

  localparam int IDLE_LIMIT = 20000000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] in_coord = '0;
  logic                      in_last = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [DIST_W-1:0]         out_median_distance;
  logic                      out_error;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [DIMS_W-1:0]         cfg_wdata = '0;

  logic              mode_q;
  logic [DIMS_W-1:0] dims_q;
  shortint           point_coords[$];
  bit                store_full;
  median_result_t    pending_medians[$];

  int fail_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int quiet_cycles;

  pairwise_distance_median_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_coord(in_coord), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_median_distance(out_median_distance), .out_error(out_error),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Takes one accepted coordinate and, on the end of a set, queues the expected median.
  task automatic predict_beat(input shortint c, input logic l);
    median_result_t    r;
    longint unsigned   dist_list[$];
    longint unsigned   acc;
    longint            d;
    int                npts;
    bit                bad;
    if (point_coords.size() < STORE_DEPTH) point_coords = {point_coords, c};
    else store_full = 1;
    if (!l) return;
    bad = store_full || dims_q == 0 || dims_q > MAX_DIMS;
    npts = 0;
    if (!bad) begin
      if (point_coords.size() % dims_q != 0) bad = 1;
      else npts = point_coords.size() / dims_q;
    end
    if (!bad && (npts < 2 || npts > MAX_POINTS)) bad = 1;
    r.median = '0;
    r.err = bad;
    if (!bad) begin
      for (int i = 0; i < npts - 1; i++) begin
        for (int j = i + 1; j < npts; j++) begin
          acc = 0;
          for (int k = 0; k < dims_q; k++) begin
            d = longint'(point_coords[i*dims_q+k]) - longint'(point_coords[j*dims_q+k]);
            if (d < 0) d = -d;
            acc += mode_q ? longint'(d * d) : longint'(d);
          end
          dist_list = {dist_list, acc};
        end
      end
      dist_list.sort();
      r.median = dist_list[(dist_list.size() - 1) / 2][DIST_W-1:0];
    end
    pending_medians = {pending_medians, r};
    point_coords.delete();
    store_full = 0;
  endtask

  task automatic send_beat(input shortint c, input logic l);
    in_valid <= 1'b1;
    in_coord <= c;
    in_last  <= l;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    predict_beat(c, l);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic shortint pick_coord(input int spread);
    case (spread)
      0: return shortint'($urandom);
      1: return shortint'($urandom_range(0, 7)) - 4;
      default: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  // Sends ncoords coordinates, the last of them flagged.
  task automatic send_set(input int ncoords, input int spread);
    for (int i = 0; i < ncoords; i++) send_beat(pick_coord(spread), i == ncoords - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIMS_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_KERNEL_MODE) mode_q = val[0];
    else dims_q = val;
  endtask

  task automatic set_config(input logic m, input logic [DIMS_W-1:0] nd);
    wait_drained();
    write_reg(REG_KERNEL_MODE, {{(DIMS_W-1){1'b0}}, m});
    write_reg(REG_DIMS, nd);
    cfg_we <= 1'b0;
  endtask

  task automatic test_extremes();
    set_config(1'b1, 4'd8);
    send_beat(16'sh8000, 0); repeat (7) send_beat(16'sh8000, 0);
    repeat (7) send_beat(16'sh7fff, 0); send_beat(16'sh7fff, 1);
    set_config(1'b0, 4'd1);
    send_beat(16'sh7fff, 0); send_beat(16'sh8000, 0); send_beat(16'sh0000, 1);
    set_config(1'b1, 4'd3);
    send_set(9, 2);
  endtask

  task automatic test_error_cases();
    set_config(1'b0, 4'd2);
    send_set(2, 0);
    send_set(5, 0);
    send_beat(16'sh0001, 1);
    set_config(1'b1, 4'd0);
    send_set(4, 0);
    set_config(1'b0, 4'd15);
    send_set(30, 0);
    set_config(1'b1, 4'd1);
    send_set(MAX_POINTS + 1, 0);
    send_set(MAX_POINTS, 1);
    set_config(1'b0, 4'd8);
    send_set(STORE_DEPTH + 3, 0);
    send_set(16, 1);
  endtask

  task automatic test_larger_set();
    set_config(1'b1, 4'd2);
    send_set(2 * 24, 0);
  endtask

  task automatic test_backpressure();
    set_config(1'b0, 4'd1);
    send_idle_pct = 0;
    hold_left = 400;
    for (int i = 0; i < 6; i++) send_set($urandom_range(2, 5), 1);
    wait_drained();
    send_set(3, 0);
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int nitems);
    int sent;
    int npts;
    int ncoords;
    set_config(1'($urandom_range(1)), DIMS_W'($urandom_range(1, MAX_DIMS)));
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < nitems) begin
      if ($urandom_range(9) == 0) begin
        set_config(1'($urandom_range(1)), DIMS_W'($urandom_range(1, MAX_DIMS)));
      end
      npts = $urandom_range(2, 8);
      ncoords = npts * dims_q;
      if ($urandom_range(9) == 0) ncoords = $urandom_range(1, 2 * dims_q + 1);
      send_set(ncoords, $urandom_range(3) == 0 ? 1 : 0);
      sent += ncoords;
    end
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_medians.size() == 0) begin
          $display("%0t: unexpected result median=%0d error=%0b", $time,
                   out_median_distance, out_error);
          fail_count++;
        end else begin
          if (out_median_distance !== pending_medians[0].median ||
              out_error !== pending_medians[0].err) begin
            $display("%0t: mismatch expected median=%0d error=%0b actual median=%0d error=%0b",
                     $time, pending_medians[0].median, pending_medians[0].err,
                     out_median_distance, out_error);
            fail_count++;
          end
          void'(pending_medians.pop_front());
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("pairwise_distance_median_top_test: FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    mode_q = 1'b0;
    dims_q = 4'd1;
    store_full = 0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    quiet_cycles = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_error_cases();
    test_larger_set();
    test_backpressure();
    test_random_phase(0, 0, 125);
    test_random_phase(79, 0, 125);
    test_random_phase(0, 79, 125);
    test_random_phase(27, 27, 125);
    wait_drained();
    if (fail_count == 0) begin
      $display("pairwise_distance_median_top_test: PASS");
    end else begin
      $display("pairwise_distance_median_top_test: FAIL");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pdm_pkg.sv
rtl/pdm_ram.sv
rtl/pdm_dist.sv
rtl/pdm_sel.sv
rtl/pairwise_distance_median_top.sv
rtl/pdm_checker.sv
tb/pairwise_distance_median_top_test.sv
